### rtl/bdq_pkg.sv
// Package for the bounded deque: field widths, action and status codes,
// controller states and the command/status structs between the two halves.
// No dependencies.
package bdq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int ACTION_W      = 3;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_SET_FRONT  = 3'd2,
    ACT_SET_BACK   = 3'd3,
    ACT_POP_FRONT  = 3'd4,
    ACT_POP_BACK   = 3'd5,
    ACT_CLEAR      = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the request on an input transfer
    logic exec;   // carry out the request, update pointers, issue the read
    logic fetch;  // move the read data into the result register
  } bdq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_ok; // the request held is a pop that will return a value
  } bdq_stat_t;

endpackage

### rtl/bdq_if.sv
// Handshake channels of the bounded deque: request channel and result channel.
// Depends on bdq_pkg for the field widths.
interface bdq_req_if
  import bdq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface bdq_rsp_if
  import bdq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  popped;
  logic [COUNT_W-1:0]         count;

  modport source (output valid, output status, output popped, output count, input ready);
  modport sink   (input valid, input status, input popped, input count, output ready);
endinterface

### rtl/bounded_deque_top.sv
// Top level of the bounded deque: a ring-buffer double-ended queue of signed
// 32-bit values. Depends on bdq_pkg, bdq_if, bdq_ctrl and bdq_datapath.
//
//   Channel   Direction  Handshake     Payload
//   in_chan   sink       valid/ready   action[2:0], value[31:0] signed
//   out_chan  source     valid/ready   status[1:0], popped[31:0] signed, count[4:0]
//
// Each request produces exactly one result. A request that is not a successful
// pop goes from its transfer through the execute step against the ring buffer
// into the result register, and its result may then transfer. A successful pop
// also passes through the registered memory read before the value reaches the
// result register. A new request is taken no earlier than the cycle in which
// its predecessor's result transfers, and may be taken in that same cycle.
// Reset (rst_n, synchronous, active low) empties the queue; slot contents are
// not cleared since only held entries are ever read. While a result waits
// for out_chan.ready the block holds it and takes no new request.
module bounded_deque_top
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  bdq_req_if.sink    in_chan,
  bdq_rsp_if.source  out_chan
);

  bdq_cmd_t  cmd;
  bdq_stat_t stat;

  // The controller owns the handshake; the datapath owns the payload.
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (in_chan.action),
    .in_value   (in_chan.value),
    .out_status (out_chan.status),
    .out_popped (out_chan.popped),
    .out_count  (out_chan.count)
  );

endmodule

### rtl/bdq_ctrl.sv
// Controller of the bounded deque: sequences capture, execute, read-out and
// result hand-off. Depends on bdq_pkg.
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bdq_stat_t stat,
  output bdq_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.pop_ok ? S_FETCH : S_OUT;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        // A new request may come in during the same cycle as the result leaves.
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.load  = 1'b1;
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/bdq_datapath.sv
// Datapath of the bounded deque: request register, ring buffer memory,
// front pointer and entry count, and the result register. Depends on bdq_pkg.
module bdq_datapath
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bdq_cmd_t                  cmd,
  output bdq_stat_t                 stat,
  input  logic [ACTION_W-1:0]       in_action,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic [STATUS_W-1:0]       out_status,
  output logic signed [VALUE_W-1:0] out_popped,
  output logic [COUNT_W-1:0]        out_count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  logic [VALUE_W-1:0] mem [DEPTH];

  action_t             action_r;
  logic [VALUE_W-1:0]  value_r;
  logic [PTR_W-1:0]    front_r;
  logic [PTR_W-1:0]    front_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [VALUE_W-1:0]  rd_data_r;
  status_t             status_r;
  status_t             status_nxt;
  logic [VALUE_W-1:0]  popped_r;
  logic [CNT_W-1:0]    count_r;

  logic                full;
  logic                empty;
  logic [PTR_W-1:0]    front_dec;
  logic [PTR_W-1:0]    front_inc;
  logic [SUM_W-1:0]    tail_sum;
  logic [SUM_W-1:0]    back_sum;
  logic [PTR_W-1:0]    tail_idx;
  logic [PTR_W-1:0]    back_idx;
  logic                wr_en;
  logic [PTR_W-1:0]    wr_addr;
  logic [PTR_W-1:0]    rd_addr;
  logic                pop_ok;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  assign front_dec = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == PTR_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;

  // Slot after the back entry, and the back entry itself; both sums stay
  // below twice the depth, so one conditional subtract wraps them.
  assign tail_sum = SUM_W'(front_r) + SUM_W'(cnt_r);
  assign back_sum = tail_sum - 1'b1;
  assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(tail_sum);
  assign back_idx = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(back_sum);

  always_comb begin
    status_nxt = ST_OK;
    front_nxt  = front_r;
    cnt_nxt    = cnt_r;
    wr_en      = 1'b0;
    wr_addr    = front_r;
    rd_addr    = front_r;
    pop_ok     = 1'b0;
    unique case (action_r)
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          front_nxt = front_dec;
          wr_en     = 1'b1;
          wr_addr   = front_dec;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = tail_idx;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ACT_SET_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          wr_en = 1'b1;
        end
      end
      ACT_SET_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          wr_en   = 1'b1;
          wr_addr = back_idx;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          pop_ok    = 1'b1;
          front_nxt = front_inc;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          pop_ok  = 1'b1;
          rd_addr = back_idx;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ACT_CLEAR: begin
        front_nxt = '0;
        cnt_nxt   = '0;
      end
      default: begin
        // Unused code: nothing changes and the status is ok.
      end
    endcase
  end

  assign stat.pop_ok = pop_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= action_t'(in_action);
      value_r  <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      count_r  <= cnt_nxt;
      popped_r <= '0;
    end else if (cmd.fetch) begin
      popped_r <= rd_data_r;
    end
  end

  assign out_status = status_r;
  assign out_popped = popped_r;
  assign out_count  = COUNT_W'(count_r);

endmodule
